// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    `ASSERT_CLK(label, clk, rstn, !(cond), msg)

`endif

// ----- rtl/cpu8_pkg.sv -----
package cpu8_pkg;

    localparam int unsigned REVERSE_LIMIT = 1200;

    localparam logic [15:0] UPPER_MAP [128] = '{
        16'd199,  16'd252,  16'd233,  16'd226,  16'd228,  16'd224,  16'd229,  16'd231,
        16'd234,  16'd235,  16'd232,  16'd239,  16'd238,  16'd236,  16'd196,  16'd197,
        16'd201,  16'd230,  16'd198,  16'd244,  16'd246,  16'd242,  16'd251,  16'd249,
        16'd255,  16'd214,  16'd220,  16'd162,  16'd163,  16'd165,  16'd8359, 16'd402,
        16'd225,  16'd237,  16'd243,  16'd250,  16'd241,  16'd209,  16'd170,  16'd186,
        16'd191,  16'd8976, 16'd172,  16'd189,  16'd188,  16'd161,  16'd171,  16'd187,
        16'd9617, 16'd9618, 16'd9619, 16'd9474, 16'd9508, 16'd9569, 16'd9570, 16'd9558,
        16'd9557, 16'd9571, 16'd9553, 16'd9559, 16'd9565, 16'd9564, 16'd9563, 16'd9488,
        16'd9492, 16'd9524, 16'd9516, 16'd9500, 16'd9472, 16'd9532, 16'd9566, 16'd9567,
        16'd9562, 16'd9556, 16'd9577, 16'd9574, 16'd9568, 16'd9552, 16'd9580, 16'd9575,
        16'd9576, 16'd9572, 16'd9573, 16'd9561, 16'd9560, 16'd9554, 16'd9555, 16'd9579,
        16'd9578, 16'd9496, 16'd9484, 16'd9608, 16'd9604, 16'd9612, 16'd9616, 16'd9600,
        16'd945,  16'd223,  16'd915,  16'd960,  16'd931,  16'd963,  16'd181,  16'd964,
        16'd934,  16'd920,  16'd937,  16'd948,  16'd8734, 16'd966,  16'd949,  16'd8745,
        16'd8801, 16'd177,  16'd8805, 16'd8804, 16'd8992, 16'd8993, 16'd247,  16'd8776,
        16'd176,  16'd8729, 16'd183,  16'd8730, 16'd8319, 16'd178,  16'd9632, 16'd160
    };

    // up to three output bytes produced by one input byte
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] data;
        logic            string_end;
    } grp_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } lookup_t;

    // highest matching table entry wins
    function automatic lookup_t rev_lookup(input logic [15:0] cp);
        lookup_t r;
        r.hit  = 1'b0;
        r.code = 8'h00;
        for (int i = 0; i < 128; i++) begin
            if (UPPER_MAP[i] == cp) begin
                r.hit  = 1'b1;
                r.code = 8'h80 | 8'(i);
            end
        end
        if (32'(cp) >= REVERSE_LIMIT) begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/cpu8_decode.sv -----
`include "assert_macros.svh"

module cpu8_decode (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             direction,
    output cpu8_pkg::grp_t   grp
);

    typedef enum logic [1:0] {
        PEND_IDLE,
        PEND_TWO_FINAL,
        PEND_THREE_FINAL,
        PEND_THREE_MID
    } pend_t;

    pend_t pend_reg, pend_next;
    logic [9:0] part_reg, part_next;

    logic [15:0] fwd_cp;
    logic [15:0] rev_cp;
    logic        rev_floor_ok;
    logic        standalone;
    cpu8_pkg::lookup_t look;

    assign fwd_cp = in_byte[7] ? cpu8_pkg::UPPER_MAP[in_byte[6:0]] : {8'h00, in_byte};
    assign rev_cp = {part_reg, in_byte[5:0]};
    assign rev_floor_ok = (pend_reg == PEND_TWO_FINAL) ? (rev_cp >= 16'h0080)
                                                        : (rev_cp >= 16'h0800);
    assign look = cpu8_pkg::rev_lookup(rev_cp);

    always_comb begin
        pend_next      = pend_reg;
        part_next      = part_reg;
        standalone     = 1'b0;
        grp.count      = 2'd0;
        grp.data       = '0;
        grp.string_end = in_last;
        if (!direction) begin
            pend_next = PEND_IDLE;
            part_next = '0;
            if (fwd_cp < 16'h0080) begin
                grp.count   = 2'd1;
                grp.data[0] = fwd_cp[7:0];
            end else if (fwd_cp < 16'h0800) begin
                grp.count   = 2'd2;
                grp.data[0] = {3'b110, fwd_cp[10:6]};
                grp.data[1] = {2'b10, fwd_cp[5:0]};
            end else begin
                grp.count   = 2'd3;
                grp.data[0] = {4'b1110, fwd_cp[15:12]};
                grp.data[1] = {2'b10, fwd_cp[11:6]};
                grp.data[2] = {2'b10, fwd_cp[5:0]};
            end
        end else begin
            case (pend_reg)
                PEND_THREE_MID: begin
                    if (in_last) begin
                        standalone = 1'b1;
                    end else begin
                        part_next = {part_reg[3:0], in_byte[5:0]};
                        pend_next = PEND_THREE_FINAL;
                    end
                end
                PEND_TWO_FINAL, PEND_THREE_FINAL: begin
                    if (rev_floor_ok && look.hit) begin
                        grp.count   = 2'd1;
                        grp.data[0] = look.code;
                    end
                    pend_next = PEND_IDLE;
                    part_next = '0;
                end
                default: begin
                    standalone = 1'b1;
                end
            endcase
            if (standalone) begin
                if (!in_byte[7]) begin
                    grp.count   = 2'd1;
                    grp.data[0] = in_byte;
                end else if (in_byte[7:5] == 3'b110) begin
                    if (!in_last) begin
                        part_next = {5'b00000, in_byte[4:0]};
                        pend_next = PEND_TWO_FINAL;
                    end
                end else if (in_byte[7:4] == 4'b1110) begin
                    if (!in_last) begin
                        part_next = {6'b000000, in_byte[3:0]};
                        pend_next = PEND_THREE_MID;
                    end
                end
            end
            if (in_last) begin
                pend_next = PEND_IDLE;
                part_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_IDLE;
            part_reg <= '0;
        end else if (advance) begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

    `ASSERT_CLK(a_last_returns_idle, aclk, aresetn,
        (advance && in_last) |=> (pend_reg == PEND_IDLE), "decoder not idle after end of string")
    `ASSERT_NEVER(a_mid_payload_narrow, aclk, aresetn,
        (pend_reg == PEND_THREE_MID) && (part_reg[9:4] != 6'd0), "3-byte lead payload too wide")
    `ASSERT_NEVER(a_two_payload_narrow, aclk, aresetn,
        (pend_reg == PEND_TWO_FINAL) && (part_reg[9:5] != 5'd0), "2-byte lead payload too wide")

endmodule

// ----- rtl/cpu8_serializer.sv -----
`include "assert_macros.svh"

module cpu8_serializer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  cpu8_pkg::grp_t grp,
    output logic           free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic           m_tlast,   // run_last
    output logic [0:0]     m_tuser    // string_end
);

    logic            valid_reg;
    logic [1:0]      cnt_reg;
    logic [1:0]      idx_reg;
    logic [2:0][7:0] data_reg;
    logic            end_reg;
    logic            run_last;

    assign run_last = (idx_reg == (cnt_reg - 2'd1));
    assign free     = !valid_reg || (m_tready && run_last);

    assign m_tvalid   = valid_reg;
    assign m_tlast    = run_last;
    assign m_tuser[0] = end_reg;

    always_comb begin
        case (idx_reg)
            2'd0:    m_tdata = data_reg[0];
            2'd1:    m_tdata = data_reg[1];
            2'd2:    m_tdata = data_reg[2];
            default: m_tdata = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            cnt_reg   <= grp.count;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_tready) begin
            if (run_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= grp.data;
            end_reg  <= grp.string_end;
        end
    end

    `ASSERT_NEVER(a_count_nonzero, aclk, aresetn,
        valid_reg && (cnt_reg == 2'd0), "empty byte group held")
    `ASSERT_NEVER(a_index_in_range, aclk, aresetn,
        valid_reg && (idx_reg >= cnt_reg), "byte index past group end")
    `ASSERT_CLK(a_group_continues, aclk, aresetn,
        (valid_reg && m_tready && !run_last) |=> (valid_reg && (idx_reg != 2'd0)),
        "group ended early")
    `ASSERT_NEVER(a_load_when_free, aclk, aresetn,
        load && !free, "group overwritten before drained")

endmodule

// ----- rtl/cp437_utf8_transcoder.sv -----
// path: an input byte is registered, decoded and loaded into the output serializer
// throughput: the serializer sends one output byte per cycle while m_tready is high;
// a forward byte expanding to 2 or 3 utf-8 bytes holds the next input byte in the
// input register until its group drains; bytes yielding nothing never load the serializer
// reset: aresetn synchronous active low, clears direction, decoder state and valids
module cp437_utf8_transcoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,   // direction
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte
    input  logic       s_tlast,    // last_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic       m_tlast,    // run_last
    output logic [0:0] m_tuser     // string_end
);

    logic           dir_reg;
    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           in_last_reg;
    logic           free;
    logic           advance;
    cpu8_pkg::grp_t grp;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && free;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg      <= 1'b0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                dir_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    cpu8_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .direction (dir_reg),
        .grp       (grp)
    );

    cpu8_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && (grp.count != 2'd0)),
        .grp      (grp),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/cp437_utf8_transcoder_test.sv -----
module cp437_utf8_transcoder_test;

    typedef enum logic {
        DIR_TO_UTF8  = 1'b0,
        DIR_TO_CP437 = 1'b1
    } xlate_dir_t;

    typedef enum logic [1:0] {
        DEC_IDLE  = 2'd0,
        DEC_LAST2 = 2'd1,
        DEC_LAST3 = 2'd2,
        DEC_MID   = 2'd3
    } dec_phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    typedef struct packed {
        xlate_dir_t  dir;
        logic [7:0]  in_byte;
        logic        last;
        logic [2:0]  n_out;
        logic [23:0] bytes;    // first output byte in the top bits
    } stim_row_t;

    localparam logic [2:0] BY_PREDICTOR  = 3'd7;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         WATCHDOG_MAX  = 2000;
    localparam int         PHASE_ITEMS   = 25;
    localparam int         N_PHASES      = 8;
    localparam int         N_DIRECTED    = 25;
    localparam logic [15:0] CP_LIMIT     = 16'd1200;

    localparam logic [15:0] CP437_HIGH [128] = '{
        16'd199,  16'd252,  16'd233,  16'd226,  16'd228,  16'd224,  16'd229,  16'd231,
        16'd234,  16'd235,  16'd232,  16'd239,  16'd238,  16'd236,  16'd196,  16'd197,
        16'd201,  16'd230,  16'd198,  16'd244,  16'd246,  16'd242,  16'd251,  16'd249,
        16'd255,  16'd214,  16'd220,  16'd162,  16'd163,  16'd165,  16'd8359, 16'd402,
        16'd225,  16'd237,  16'd243,  16'd250,  16'd241,  16'd209,  16'd170,  16'd186,
        16'd191,  16'd8976, 16'd172,  16'd189,  16'd188,  16'd161,  16'd171,  16'd187,
        16'd9617, 16'd9618, 16'd9619, 16'd9474, 16'd9508, 16'd9569, 16'd9570, 16'd9558,
        16'd9557, 16'd9571, 16'd9553, 16'd9559, 16'd9565, 16'd9564, 16'd9563, 16'd9488,
        16'd9492, 16'd9524, 16'd9516, 16'd9500, 16'd9472, 16'd9532, 16'd9566, 16'd9567,
        16'd9562, 16'd9556, 16'd9577, 16'd9574, 16'd9568, 16'd9552, 16'd9580, 16'd9575,
        16'd9576, 16'd9572, 16'd9573, 16'd9561, 16'd9560, 16'd9554, 16'd9555, 16'd9579,
        16'd9578, 16'd9496, 16'd9484, 16'd9608, 16'd9604, 16'd9612, 16'd9616, 16'd9600,
        16'd945,  16'd223,  16'd915,  16'd960,  16'd931,  16'd963,  16'd181,  16'd964,
        16'd934,  16'd920,  16'd937,  16'd948,  16'd8734, 16'd966,  16'd949,  16'd8745,
        16'd8801, 16'd177,  16'd8805, 16'd8804, 16'd8992, 16'd8993, 16'd247,  16'd8776,
        16'd176,  16'd8729, 16'd183,  16'd8730, 16'd8319, 16'd178,  16'd9632, 16'd160
    };

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{DIR_TO_UTF8,  8'h00, 1'b0, 3'd1,         24'h000000},
        '{DIR_TO_UTF8,  8'h7F, 1'b0, 3'd1,         24'h7F0000},
        '{DIR_TO_UTF8,  8'h80, 1'b0, 3'd2,         24'hC38700},
        '{DIR_TO_UTF8,  8'h9E, 1'b0, 3'd3,         24'hE282A7},
        '{DIR_TO_UTF8,  8'hB0, 1'b0, BY_PREDICTOR, 24'h000000},
        '{DIR_TO_UTF8,  8'hE1, 1'b0, BY_PREDICTOR, 24'h000000},
        '{DIR_TO_UTF8,  8'hFF, 1'b1, 3'd2,         24'hC2A000},
        '{DIR_TO_CP437, 8'h41, 1'b0, 3'd1,         24'h410000},
        '{DIR_TO_CP437, 8'hC3, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'h87, 1'b0, 3'd1,         24'h800000},
        '{DIR_TO_CP437, 8'hE2, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'h82, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hA7, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'h80, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hF0, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hC2, 1'b1, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hE2, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'h41, 1'b1, 3'd1,         24'h410000},
        '{DIR_TO_CP437, 8'hC1, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'h81, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hE0, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'h9F, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hBF, 1'b0, 3'd0,         24'h000000},
        '{DIR_TO_CP437, 8'hC2, 1'b0, BY_PREDICTOR, 24'h000000},
        '{DIR_TO_CP437, 8'h20, 1'b1, BY_PREDICTOR, 24'h000000}
    };

    localparam xlate_dir_t PHASE_DIR [N_PHASES] = '{
        DIR_TO_CP437, DIR_TO_UTF8, DIR_TO_CP437, DIR_TO_CP437,
        DIR_TO_UTF8, DIR_TO_CP437, DIR_TO_UTF8, DIR_TO_CP437
    };
    localparam int PHASE_SRC_IDLE [N_PHASES]   = '{0, 66, 0, 7, 0, 66, 0, 7};
    localparam int PHASE_SINK_STALL [N_PHASES] = '{0, 0, 66, 7, 0, 0, 66, 7};

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    xlate_dir_t  dir_mode    = DIR_TO_UTF8;
    dec_phase_t  dec_pending = DEC_IDLE;
    logic [9:0]  dec_partial = 10'd0;
    out_item_t   converted_q [$];
    out_item_t   head;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          items_sent     = 0;
    int          bytes_checked  = 0;
    int          dir_writes     = 0;
    int          fail_count     = 0;
    int          quiet_cycles   = 0;

    cp437_utf8_transcoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // converts one byte in the current direction, returns the number of output bytes
    function automatic int transcode(input logic [7:0] b, input logic l,
                                     output logic [2:0][7:0] conv);
        logic [15:0] cp;
        logic [15:0] floor_cp;
        logic        consumed;
        int          n;
        n = 0;
        conv = '0;
        consumed = 1'b0;
        if (dir_mode == DIR_TO_UTF8) begin
            dec_pending = DEC_IDLE;
            dec_partial = 10'd0;
            cp = b[7] ? CP437_HIGH[b[6:0]] : {8'h00, b};
            if (cp < 16'h80) begin
                conv[0] = cp[7:0];
                n = 1;
            end else if (cp < 16'h800) begin
                conv[0] = {3'b110, cp[10:6]};
                conv[1] = {2'b10, cp[5:0]};
                n = 2;
            end else begin
                conv[0] = {4'b1110, cp[15:12]};
                conv[1] = {2'b10, cp[11:6]};
                conv[2] = {2'b10, cp[5:0]};
                n = 3;
            end
        end else begin
            if (dec_pending == DEC_MID) begin
                if (l) begin
                    // lead dropped, this byte stands on its own
                    dec_pending = DEC_IDLE;
                    dec_partial = 10'd0;
                end else begin
                    dec_partial = {dec_partial[3:0], b[5:0]};
                    dec_pending = DEC_LAST3;
                    consumed = 1'b1;
                end
            end else if (dec_pending == DEC_LAST2 || dec_pending == DEC_LAST3) begin
                cp = {dec_partial, b[5:0]};
                floor_cp = (dec_pending == DEC_LAST2) ? 16'h80 : 16'h800;
                if (cp >= floor_cp && cp < CP_LIMIT) begin
                    for (int i = 0; i < 128; i++) begin
                        if (CP437_HIGH[i] == cp) begin
                            conv[0] = 8'h80 + 8'(i);
                            n = 1;
                        end
                    end
                end
                dec_pending = DEC_IDLE;
                dec_partial = 10'd0;
                consumed = 1'b1;
            end
            if (!consumed) begin
                if (!b[7]) begin
                    conv[0] = b;
                    n = 1;
                end else if (b[7:5] == 3'b110) begin
                    if (!l) begin
                        dec_partial = {5'd0, b[4:0]};
                        dec_pending = DEC_LAST2;
                    end
                end else if (b[7:4] == 4'b1110) begin
                    if (!l) begin
                        dec_partial = {6'd0, b[3:0]};
                        dec_pending = DEC_MID;
                    end
                end
            end
            if (l) begin
                dec_pending = DEC_IDLE;
                dec_partial = 10'd0;
            end
        end
        return n;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l,
                             input logic [2:0] n_typed = BY_PREDICTOR,
                             input logic [23:0] typed = 24'h000000);
        logic [2:0][7:0] conv;
        int              n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        n = transcode(b, l, conv);
        if (n_typed != BY_PREDICTOR) begin
            n = int'(n_typed);
            conv = {typed[7:0], typed[15:8], typed[23:16]};
        end
        for (int k = 0; k < n; k++) begin
            converted_q.push_back('{out_byte: conv[k], run_last: (k == n - 1),
                                    string_end: l});
        end
    endtask

    task automatic write_direction(input xlate_dir_t d);
        s_tvalid <= 1'b0;
        while (converted_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dir_mode = d;
        dir_writes++;
    endtask

    // one utf-8 character, mostly well formed, sometimes noise or cut short
    task automatic send_utf8_unit();
        logic [7:0]  seq [$];
        logic [15:0] cp;
        logic        end_str;
        int unsigned kind;
        kind = $urandom_range(9);
        end_str = ($urandom_range(7) == 0);
        cp = CP437_HIGH[$urandom_range(127)];
        case (kind)
            0, 1: seq.push_back(8'($urandom_range(127)));
            2, 3, 4, 5: begin
                if (cp < 16'h800) begin
                    seq.push_back({3'b110, cp[10:6]});
                end else begin
                    seq.push_back({4'b1110, cp[15:12]});
                    seq.push_back({2'b10, cp[11:6]});
                end
                seq.push_back({2'b10, cp[5:0]});
            end
            6: begin
                seq.push_back({3'b110, 5'($urandom)});
                seq.push_back(8'($urandom));
            end
            7: begin
                seq.push_back({4'b1110, 4'($urandom)});
                seq.push_back(8'($urandom));
                seq.push_back(8'($urandom));
            end
            8: seq.push_back(8'($urandom));
            default: begin
                // lead cut off by end of string
                if ($urandom_range(1) == 1) begin
                    seq.push_back({3'b110, 5'($urandom)});
                end else begin
                    seq.push_back({4'b1110, 4'($urandom)});
                    seq.push_back(8'($urandom));
                end
                end_str = 1'b1;
            end
        endcase
        for (int i = 0; i < seq.size(); i++) begin
            send_byte(seq[i], end_str && (i == seq.size() - 1));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_checked++;
                if (converted_q.size() == 0) begin
                    $error("output transfer with nothing expected: out_byte %h", m_tdata);
                    fail_count++;
                end else begin
                    head = converted_q.pop_front();
                    if (m_tdata !== head.out_byte) begin
                        $error("out_byte: expected %h, got %h", head.out_byte, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== head.run_last) begin
                        $error("run_last: expected %b, got %b", head.run_last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[0] !== head.string_end) begin
                        $error("string_end: expected %b, got %b", head.string_end,
                               m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("FAIL cp437_utf8_transcoder");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_end;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_direction(DIR_TO_UTF8);
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].dir != dir_mode) begin
                write_direction(DIRECTED[r].dir);
            end
            send_byte(DIRECTED[r].in_byte, DIRECTED[r].last, DIRECTED[r].n_out,
                      DIRECTED[r].bytes);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            src_idle_pct   = PHASE_SRC_IDLE[p];
            sink_stall_pct = PHASE_SINK_STALL[p];
            write_direction(PHASE_DIR[p]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if (dir_mode == DIR_TO_UTF8) begin
                    send_byte(8'($urandom), $urandom_range(7) == 0);
                end else begin
                    send_utf8_unit();
                end
            end
        end

        s_tvalid <= 1'b0;
        while (converted_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d input bytes over %0d direction settings, checked %0d output bytes",
                 items_sent, dir_writes, bytes_checked);
        $display("both directions, corner cases and idle/stall mixes on both sides exercised");
        if (fail_count == 0) begin
            $display("PASS cp437_utf8_transcoder");
        end else begin
            $display("FAIL cp437_utf8_transcoder");
        end
        $finish;
    end

endmodule
